/* sv/srefd_pkg.sv */
`default_nettype none
package srefd_pkg;

  typedef struct packed {
    logic [11:0] column_index;
    logic [63:0] coded_value;
    logic        has_entry;
    logic        row_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  column;
    logic        present;
    logic [31:0] total_count;
    logic [9:0]  distance;
    logic [9:0]  fraction_a;
    logic [9:0]  fraction_b;
    logic [9:0]  fraction_c;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // decoded item handed from the front end to the sequencer
  typedef struct packed {
    logic [11:0] idx;
    logic        has_entry;
    logic        row_end;
    logic        is_zero;
    logic        bad_code;
    logic [31:0] count;
    logic [9:0]  distance;
    logic [9:0]  fa;
    logic [9:0]  fb;
    logic [9:0]  fc;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_COL  = 2'd1;
  localparam logic [1:0] STATUS_BAD_CODE = 2'd2;

  localparam logic [0:0] REG_NUM_COLUMNS = 1'd0;
  localparam logic [6:0] NUM_COLUMNS_RST = 7'd64;

  localparam logic [31:0] DIGIT_BASE = 32'd1001;
  localparam logic [14:0] FULL_SCALE = 15'd1000;

  // floor(2^41 / 1001): quotient estimate is exact or one short
  localparam logic [31:0] RECIP_1001  = 32'd2196826429;
  localparam int unsigned RECIP_SHIFT = 41;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

/* sv/srefd_front.sv */
`default_nettype none
module srefd_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire srefd_pkg::in_item_t  in_item_i,
  output logic                      push_o,
  output srefd_pkg::cmd_t           cmd_o,
  input  wire logic                 full_i
);

  logic adv;

  // stage 1: captured item
  logic        s1_valid_q;
  logic [11:0] s1_idx_q;
  logic        s1_ent_q, s1_end_q, s1_zero_q;
  logic [31:0] s1_count_q, s1_low_q;

  // stage 2: reciprocal product of low word
  logic        s2_valid_q;
  logic [11:0] s2_idx_q;
  logic        s2_ent_q, s2_end_q, s2_zero_q;
  logic [31:0] s2_count_q, s2_low_q;
  logic [63:0] s2_prod_q;

  // stage 3: first digit split
  logic        s3_valid_q;
  logic [11:0] s3_idx_q;
  logic        s3_ent_q, s3_end_q, s3_zero_q;
  logic [31:0] s3_count_q;
  logic [22:0] s3_quo_q;
  logic [9:0]  s3_dist_q;

  // stage 4: reciprocal product of quotient
  logic        s4_valid_q;
  logic [11:0] s4_idx_q;
  logic        s4_ent_q, s4_end_q, s4_zero_q;
  logic [31:0] s4_count_q;
  logic [22:0] s4_quo_q;
  logic [9:0]  s4_dist_q;
  logic [63:0] s4_prod_q;

  // stage 5: second digit split
  logic        s5_valid_q;
  logic [11:0] s5_idx_q;
  logic        s5_ent_q, s5_end_q, s5_zero_q;
  logic [31:0] s5_count_q;
  logic [9:0]  s5_dist_q;
  logic [12:0] s5_fa_q;
  logic [9:0]  s5_fb_q;

  logic [22:0]        qe1;
  logic [31:0]        rem1;
  logic [22:0]        quo1_d;
  logic [9:0]         dist_d;
  logic [12:0]        qe2;
  logic [22:0]        rem2;
  logic [12:0]        fa_d;
  logic [9:0]         fb_d;
  logic signed [14:0] frac_c;
  logic               bad_code;

  assign adv        = !s5_valid_q || !full_i;
  assign in_stall_o = !adv;

  always_comb begin
    qe1  = s2_prod_q[63:41];
    rem1 = s2_low_q - 32'({9'd0, qe1} * srefd_pkg::DIGIT_BASE);
    if (rem1 >= srefd_pkg::DIGIT_BASE) begin
      quo1_d = qe1 + 23'd1;
      dist_d = 10'(rem1 - srefd_pkg::DIGIT_BASE);
    end else begin
      quo1_d = qe1;
      dist_d = rem1[9:0];
    end
  end

  always_comb begin
    qe2  = s4_prod_q[53:41];
    rem2 = s4_quo_q - 23'({10'd0, qe2} * srefd_pkg::DIGIT_BASE[22:0]);
    if (rem2 >= srefd_pkg::DIGIT_BASE[22:0]) begin
      fa_d = qe2 + 13'd1;
      fb_d = 10'(rem2 - srefd_pkg::DIGIT_BASE[22:0]);
    end else begin
      fa_d = qe2;
      fb_d = rem2[9:0];
    end
  end

  // C = 1000 - A - B; -1 and -2 clamp to zero, below that the code is bad
  always_comb begin
    frac_c   = $signed(srefd_pkg::FULL_SCALE) - $signed({2'b0, s5_fa_q})
             - $signed({5'b0, s5_fb_q});
    bad_code = !s5_zero_q && ((s5_fa_q > 13'(srefd_pkg::FULL_SCALE)) || (frac_c < -15'sd2));
    cmd_o.idx       = s5_idx_q;
    cmd_o.has_entry = s5_ent_q;
    cmd_o.row_end   = s5_end_q;
    cmd_o.is_zero   = s5_zero_q;
    cmd_o.bad_code  = bad_code;
    cmd_o.count     = s5_count_q;
    cmd_o.distance  = s5_dist_q;
    cmd_o.fa        = s5_fa_q[9:0];
    cmd_o.fb        = s5_fb_q;
    cmd_o.fc        = frac_c[14] ? 10'd0 : frac_c[9:0];
  end

  assign push_o = s5_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      // items with neither an entry nor a row end do nothing and are dropped
      s1_valid_q <= in_valid_i && (in_item_i.has_entry || in_item_i.row_end);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_idx_q   <= in_item_i.column_index;
      s1_ent_q   <= in_item_i.has_entry;
      s1_end_q   <= in_item_i.row_end;
      s1_zero_q  <= (in_item_i.coded_value == 64'd0);
      s1_count_q <= in_item_i.coded_value[63:32];
      s1_low_q   <= in_item_i.coded_value[31:0];

      s2_idx_q   <= s1_idx_q;
      s2_ent_q   <= s1_ent_q;
      s2_end_q   <= s1_end_q;
      s2_zero_q  <= s1_zero_q;
      s2_count_q <= s1_count_q;
      s2_low_q   <= s1_low_q;
      s2_prod_q  <= {32'd0, s1_low_q} * {32'd0, srefd_pkg::RECIP_1001};

      s3_idx_q   <= s2_idx_q;
      s3_ent_q   <= s2_ent_q;
      s3_end_q   <= s2_end_q;
      s3_zero_q  <= s2_zero_q;
      s3_count_q <= s2_count_q;
      s3_quo_q   <= quo1_d;
      s3_dist_q  <= dist_d;

      s4_idx_q   <= s3_idx_q;
      s4_ent_q   <= s3_ent_q;
      s4_end_q   <= s3_end_q;
      s4_zero_q  <= s3_zero_q;
      s4_count_q <= s3_count_q;
      s4_quo_q   <= s3_quo_q;
      s4_dist_q  <= s3_dist_q;
      s4_prod_q  <= {41'd0, s3_quo_q} * {32'd0, srefd_pkg::RECIP_1001};

      s5_idx_q   <= s4_idx_q;
      s5_ent_q   <= s4_ent_q;
      s5_end_q   <= s4_end_q;
      s5_zero_q  <= s4_zero_q;
      s5_count_q <= s4_count_q;
      s5_dist_q  <= s4_dist_q;
      s5_fa_q    <= fa_d;
      s5_fb_q    <= fb_d;
    end
  end

endmodule
`default_nettype wire

/* sv/srefd_fifo.sv */
`default_nettype none
module srefd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire srefd_pkg::cmd_t  data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output srefd_pkg::cmd_t       data_o,
  output logic                  empty_o
);

  localparam int unsigned Depth = srefd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  srefd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* sv/srefd_back.sv */
`default_nettype none
module srefd_back #(
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [6:0]            num_columns_i,
  input  wire logic                  empty_i,
  input  wire srefd_pkg::cmd_t       cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output srefd_pkg::out_item_t       out_item_o
);

  localparam logic [6:0] MaxCols = 7'(MAX_COLUMNS);

  srefd_pkg::back_state_e state_q, state_d;
  srefd_pkg::cmd_t        cur_q;
  logic                   ent_q, ent_d;
  logic [6:0]             nc_q, nc_d;
  logic                   out_valid_q;
  srefd_pkg::out_item_t   out_q, res;

  logic [6:0]  ncols;
  logic [6:0]  idx_next;
  logic        can_emit, emit, done, bad_col, row_more;

  assign ncols    = (num_columns_i > MaxCols) ? MaxCols : num_columns_i;
  assign can_emit = !out_valid_q || !out_stall_i;
  assign bad_col  = (cur_q.idx >= {5'd0, ncols}) || (cur_q.idx < {5'd0, nc_q});
  assign idx_next = cur_q.idx[6:0] + 7'd1;
  // row-end entry short of the last column: more fill follows after it
  assign row_more = cur_q.row_end && (idx_next < ncols);

  always_comb begin
    state_d = state_q;
    case (state_q)
      srefd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = srefd_pkg::BK_RUN;
        end
      end
      srefd_pkg::BK_RUN: begin
        if (done) begin
          state_d = srefd_pkg::BK_IDLE;
        end
      end
      default: state_d = srefd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    emit   = 1'b0;
    done   = 1'b0;
    nc_d   = nc_q;
    ent_d  = ent_q;
    res    = '0;
    res.status = srefd_pkg::STATUS_OK;
    case (state_q)
      srefd_pkg::BK_IDLE: begin
        pop_o = !empty_i;
      end
      srefd_pkg::BK_RUN: begin
        if (ent_q) begin
          if (can_emit) begin
            emit = 1'b1;
            if (bad_col || cur_q.bad_code) begin
              res.status = bad_col ? srefd_pkg::STATUS_BAD_COL : srefd_pkg::STATUS_BAD_CODE;
              res.last   = 1'b1;
              nc_d       = '0;
              done       = 1'b1;
            end else if ({5'd0, nc_q} < cur_q.idx) begin
              res.column = nc_q[5:0];
              nc_d       = nc_q + 7'd1;
            end else begin
              res.column = cur_q.idx[5:0];
              if (!cur_q.is_zero) begin
                res.present     = 1'b1;
                res.total_count = cur_q.count;
                res.distance    = cur_q.distance;
                res.fraction_a  = cur_q.fa;
                res.fraction_b  = cur_q.fb;
                res.fraction_c  = cur_q.fc;
              end
              res.last = !row_more;
              ent_d    = 1'b0;
              nc_d     = (cur_q.row_end && !row_more) ? 7'd0 : idx_next;
              done     = !row_more;
            end
          end
        end else if (nc_q >= ncols) begin
          // row already full or shortened: nothing to fill
          nc_d = '0;
          done = 1'b1;
        end else if (can_emit) begin
          emit       = 1'b1;
          res.column = nc_q[5:0];
          res.last   = (nc_q + 7'd1 == ncols);
          nc_d       = res.last ? 7'd0 : nc_q + 7'd1;
          done       = res.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srefd_pkg::BK_IDLE;
      nc_q        <= '0;
      ent_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nc_q    <= nc_d;
      ent_q   <= pop_o ? cmd_i.has_entry : ent_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* sv/sparse_row_expand_fiber_decode.sv */
`default_nettype none
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------
// input    | in_valid_i/in_stall_o | in_item_i (srefd_pkg::in_item_t)
// output   | out_valid_o/out_stall_i | out_item_o (srefd_pkg::out_item_t)
// config   | psel/penable/pwrite   | paddr, pwdata, prdata (num_columns)
//
// Front end splits the fiber word into base-1001 digits in a five-stage
// pipeline (two reciprocal multiplies), then a two-entry queue feeds the
// row sequencer. It emits one result per cycle unless the output stalls,
// after a load step per item; it pops no new item until the last is done.
// Reset clears the pipeline, queue, column counter and sets num_columns to 64.
// Output stall holds the output register; the queue absorbs the front end.
module sparse_row_expand_fiber_decode #(
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire srefd_pkg::in_item_t   in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output srefd_pkg::out_item_t       out_item_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [6:0]      num_columns_q;
  logic            push, pop, full, empty;
  srefd_pkg::cmd_t cmd_push, cmd_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == srefd_pkg::REG_NUM_COLUMNS) ? {25'd0, num_columns_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_columns_q <= srefd_pkg::NUM_COLUMNS_RST;
    end else if (psel && penable && pwrite && (paddr[2] == srefd_pkg::REG_NUM_COLUMNS)) begin
      num_columns_q <= pwdata[6:0];
    end
  end

  srefd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (cmd_push),
    .full_i     (full)
  );

  srefd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_push),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_pop),
    .empty_o (empty)
  );

  srefd_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_columns_i (num_columns_q),
    .empty_i       (empty),
    .cmd_i         (cmd_pop),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule
`default_nettype wire
